// File: sv/ipr_pkg.sv
// Shared types, codes and defaults for the address range region table.
package ipr_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_REPLACED = 3'd1,
      ST_FULL     = 3'd2,
      ST_HIT      = 3'd3,
      ST_MISS     = 3'd4
   } status_type;

   // One queued request: host-order address, codes {country, province, city}.
   typedef struct packed {
      logic        op;
      logic [31:0] addr;
      logic [47:0] codes;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SRCH,
      BK_CMP,
      BK_CHECK,
      BK_SHIFT_RD,
      BK_SHIFT_WR,
      BK_WRITE,
      BK_RESP
   } back_state_type;

endpackage

// File: sv/ipr_front.sv
// Front end: classifies requests, byte-swaps lookup addresses, two-entry queue.
module ipr_front
   import ipr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        in_op,
   input  logic [31:0] in_addr,
   input  logic [47:0] in_codes,
   output logic        out_valid,
   input  logic        out_ready,
   output item_type    out_item
);

   item_type   q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   item;
   logic       push, pop;

   always_comb begin
      item.op    = in_op;
      item.codes = in_codes;
      if (in_op == OP_LOOKUP) begin
         item.addr = {in_addr[7:0], in_addr[15:8], in_addr[23:16], in_addr[31:24]};
      end else begin
         item.addr = in_addr;
      end
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = q_ff[rptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;
   assign wptr_in   = wptr_ff ^ push;
   assign rptr_in   = rptr_ff ^ pop;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= item;
      end
   end

endmodule

// File: sv/ipr_back.sv
// Back end: binary search, insert shifting and the sorted entry memory.
module ipr_back
   import ipr_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output status_type  rsp_status,
   output logic [47:0] rsp_codes
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   // entry: {end key, codes}
   logic [79:0] mem [TABLE_DEPTH];
   logic [79:0] rdata_ff;

   back_state_type state_ff, state_in;
   logic [CW-1:0]  lo_ff, hi_ff, idx_ff, count_ff, mid;
   item_type       item_ff;
   status_type     status_ff;
   logic [47:0]    codes_ff;

   logic           rd_en, wr_en;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic [79:0]    wr_data;
   logic           in_range, key_eq, key_lt;

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign in_range = (lo_ff < count_ff);
   assign key_eq   = (rdata_ff[79:48] == item_ff.addr);
   assign key_lt   = (rdata_ff[79:48] < item_ff.addr);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (in_valid) state_in = BK_SRCH;
         end
         BK_SRCH: begin
            state_in = (lo_ff < hi_ff) ? BK_CMP : BK_CHECK;
         end
         BK_CMP: state_in = BK_SRCH;
         BK_CHECK: begin
            if (item_ff.op == OP_LOOKUP || (in_range && key_eq) || count_ff == DEPTH_C) begin
               state_in = BK_RESP;
            end else if (count_ff == lo_ff) begin
               state_in = BK_WRITE;
            end else begin
               state_in = BK_SHIFT_RD;
            end
         end
         BK_SHIFT_RD: state_in = BK_SHIFT_WR;
         BK_SHIFT_WR: begin
            state_in = ((idx_ff - ONE_C) == lo_ff) ? BK_WRITE : BK_SHIFT_RD;
         end
         BK_WRITE: state_in = BK_RESP;
         BK_RESP: begin
            if (rsp_ready) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      in_ready  = (state_ff == BK_IDLE);
      rsp_valid = (state_ff == BK_RESP);
      rd_en     = 1'b0;
      rd_addr   = lo_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = lo_ff[AW-1:0];
      wr_data   = {item_ff.addr, item_ff.codes};
      case (state_ff)
         BK_SRCH: begin
            rd_en   = 1'b1;
            rd_addr = (lo_ff < hi_ff) ? mid[AW-1:0] : lo_ff[AW-1:0];
         end
         BK_CHECK: begin
            wr_en = (item_ff.op == OP_INSERT) && in_range && key_eq;
         end
         BK_SHIFT_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff[AW-1:0] - AW'(1);
         end
         BK_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rdata_ff;
         end
         BK_WRITE: wr_en = 1'b1;
         default: ;
      endcase
   end

   assign rsp_status = status_ff;
   assign rsp_codes  = codes_ff;

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_WRITE) count_ff <= count_ff + ONE_C;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            item_ff <= in_item;
            lo_ff   <= '0;
            hi_ff   <= count_ff;
         end
         BK_CMP: begin
            if (key_lt) lo_ff <= mid + ONE_C;
            else        hi_ff <= mid;
         end
         BK_CHECK: begin
            codes_ff <= '0;
            idx_ff   <= count_ff;
            if (item_ff.op == OP_LOOKUP) begin
               status_ff <= in_range ? ST_HIT : ST_MISS;
               if (in_range) codes_ff <= rdata_ff[47:0];
            end else if (in_range && key_eq) begin
               status_ff <= ST_REPLACED;
            end else if (count_ff == DEPTH_C) begin
               status_ff <= ST_FULL;
            end else begin
               status_ff <= ST_INSERTED;
            end
         end
         BK_SHIFT_WR: idx_ff <= idx_ff - ONE_C;
         default: ;
      endcase
   end

endmodule

// File: sv/ip_range_region_table.sv
// Top level of the address range region table.
// A lookup or replace runs a binary search, then responds; a new end address also
// shifts each later entry up by one place and then writes the new entry.
// Throughput: one request at a time in the back end, which returns to idle after
// each response is taken; the two-entry front queue takes requests meanwhile.
// Reset: synchronous, active high; empties the table and the queue.
module ip_range_region_table
   import ipr_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // address, country_code, province_code, city_code
   input  logic        req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // country_out, isp_out, province_out, city_out
   output logic [2:0]  rsp_tuser   // status
);

   logic        q_valid, q_ready;
   item_type    q_item;
   status_type  status;
   logic [47:0] codes;

   // Front: swap lookup addresses to host order and queue the request.
   ipr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_addr   (req_tdata[31:0]),
      .in_codes  ({req_tdata[47:32], req_tdata[63:48], req_tdata[79:64]}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   // Back: search the sorted table, insert or read, hold the result.
   ipr_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_ready   (q_ready),
      .in_item    (q_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (status),
      .rsp_codes  (codes)
   );

   // isp code is never stored and reads as zero
   assign rsp_tuser = status;
   assign rsp_tdata = {codes[15:0], codes[31:16], 16'h0000, codes[47:32]};

endmodule
